[src/lzfd_pkg.sv]
// Package for the LZ frame decompressor.
// Holds the decode phase codes, header flags and shared types. No dependencies.
package lzfd_pkg;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_CWORD    = 3'd2;
  localparam logic [2:0] PH_TOKEN    = 3'd3;
  localparam logic [2:0] PH_LITERAL  = 3'd4;
  localparam logic [2:0] PH_TAIL     = 3'd5;
  localparam logic [2:0] PH_TAILSKIP = 3'd6;

  localparam logic [7:0] FLAG_LONG  = 8'h6F;
  localparam logic [7:0] FLAG_SHORT = 8'h6D;

  localparam logic [31:0] CW_EMPTY = 32'd1;
  localparam logic [31:0] CW_TAIL  = 32'h8000_0000;

  // Result word handed to the output register.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        error;
  } result_t;

  // Match token length in bytes from its first byte.
  function automatic logic [2:0] token_len(input logic [7:0] b0);
    logic [2:0] n;
    case (b0[1:0])
      2'd0:    n = 3'd1;
      2'd1:    n = 3'd2;
      2'd2:    n = 3'd2;
      default: n = (b0[6:0] == 7'd3) ? 3'd4 : 3'd3;
    endcase
    return n;
  endfunction

endpackage

[src/lzfd_history.sv]
// History window memory for the LZ frame decompressor.
// One write port, one registered read port. Uses no package items.
module lzfd_history #(
  parameter int AW = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/lz_frame_decompressor_unit.sv]
// Top level of the LZ frame decompressor: header parse, control words, literals,
// match copy from the history window. Depends on lzfd_pkg and lzfd_history.
//
// One compressed byte is taken per cycle while the block is not busy. Result words
// carry the bytes that one match token copies, eight at a time, and the frame's
// final bytes; bytes left over at the end of an input word go to the history but
// are not reported. A match holds the input until its copy ends; each copied byte
// is a read of the single history read port, and the byte is written to the
// history once its read returns and the output register is free (a read of the
// byte just written is forwarded). Output words wait in a one-entry register;
// the input also stalls while that register is full and the receiver stalls.
// WINDOW_BYTES must be a power of two.
module lz_frame_decompressor_unit #(
  parameter int WINDOW_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_count_o,
  output logic        out_last_o,
  output logic        out_error_o
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam logic [31:0] WIN = 32'(WINDOW_BYTES);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [31:0] fsize_q, fsize_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] cw_q, cw_d;
  logic [31:0] gbuf_q, gbuf_d;
  logic [2:0]  gcnt_q, gcnt_d;
  logic [2:0]  lit_q, lit_d;
  logic [63:0] pdata_q, pdata_d;
  logic [3:0]  pcnt_q, pcnt_d;

  // match copy engine
  logic        cp_q, cp_d;       // copying
  logic        rd_q, rd_d;       // a read is pending
  logic [8:0]  cplen_q, cplen_d; // bytes still to read
  logic [31:0] off_q, off_d;

  // output register
  logic                  ovalid_q, ovalid_d;
  lzfd_pkg::result_t     ores_q, ores_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic [7:0]    last_wr_q;

  lzfd_history #(.AW(AW)) u_hist (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // a read of the position written in the same cycle returns the old contents;
  // take the byte from the write register instead
  logic          fwd, we_q;
  logic [AW-1:0] raddr_q, waddr_q;
  logic [7:0]    rd_byte;
  always_ff @(posedge clk_i) begin
    last_wr_q <= wdata;
    raddr_q <= raddr; waddr_q <= waddr; we_q <= we;
  end
  assign fwd = we_q && (raddr_q == waddr_q);
  assign rd_byte = fwd ? last_wr_q : rdata;

  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;
  // busy while copying; stall if output register could overflow
  assign in_stall_o = cp_q || !out_free;
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    logic        put_en, emit, e_last, e_err, done, do_dec, stop;
    logic [7:0]  pb;
    logic [31:0] v, off, len, npos;
    logic [2:0]  n;
    logic [3:0]  nib;
    logic [31:0] cwx;
    logic [2:0]  gc;
    logic [31:0] gb;
    phase_d = phase_q; hidx_d = hidx_q; fsize_d = fsize_q; pos_d = pos_q;
    cw_d = cw_q; gbuf_d = gbuf_q; gcnt_d = gcnt_q; lit_d = lit_q;
    pdata_d = pdata_q; pcnt_d = pcnt_q;
    cp_d = cp_q; rd_d = 1'b0; cplen_d = cplen_q; off_d = off_q;
    ovalid_d = ovalid_q && out_stall_i; ores_d = ores_q;
    put_en = 1'b0; pb = in_byte_i; emit = 1'b0; e_last = 1'b0; e_err = 1'b0;
    done = 1'b0; do_dec = 1'b0; stop = 1'b0;
    v = gbuf_q; off = '0; len = '0; n = '0; nib = '0; cwx = cw_q;
    gc = gcnt_q; gb = gbuf_q; npos = pos_q;
    raddr = AW'(pos_q - off_q);

    // ---- match copy: one byte per read ----
    if (cp_q) begin
      if (rd_q && out_free) begin
        put_en = 1'b1;
        pb = rd_byte;
      end
      // issue next read only when the pending one will be consumed
      if (cplen_q != 9'd0 && (!rd_q || out_free)) begin
        // address for the byte after a pending put
        npos = (rd_q) ? pos_q + 32'd1 : pos_q;
        raddr = AW'(npos - off_q);
        rd_d = 1'b1;
        cplen_d = cplen_q - 9'd1;
      end else begin
        rd_d = rd_q && !out_free;
      end
    end else if (acc) begin
      // each input word starts an empty result word
      pdata_d = '0; pcnt_d = '0;
      if (frame_start_i) begin
        pos_d = '0; fsize_d = '0; cw_d = lzfd_pkg::CW_EMPTY;
        gbuf_d = '0; gcnt_d = '0; lit_d = '0;
        if (in_byte_i == lzfd_pkg::FLAG_LONG) begin
          phase_d = lzfd_pkg::PH_HEADER; hidx_d = 4'd1;
        end else if (in_byte_i == lzfd_pkg::FLAG_SHORT) begin
          phase_d = lzfd_pkg::PH_HEADER; hidx_d = 4'd10;
        end else begin
          hidx_d = '0; emit = 1'b1; e_err = 1'b1; phase_d = lzfd_pkg::PH_IDLE;
        end
      end else begin
        case (phase_q)
          lzfd_pkg::PH_HEADER: begin
            if (hidx_q <= 4'd8) begin
              if (hidx_q >= 4'd5) fsize_d = {in_byte_i, fsize_q[31:8]};
              hidx_d = hidx_q + 4'd1;
            end else if (hidx_q == 4'd10) begin
              hidx_d = 4'd11;
            end else begin
              fsize_d = {24'd0, in_byte_i};
            end
            if (hidx_q == 4'd8 || hidx_q == 4'd11) begin
              hidx_d = '0; pos_d = '0; lit_d = '0;
              if (fsize_d == '0) begin
                emit = 1'b1; e_last = 1'b1; phase_d = lzfd_pkg::PH_IDLE;
              end else begin
                cw_d = lzfd_pkg::CW_EMPTY; do_dec = 1'b1;
              end
            end
          end
          lzfd_pkg::PH_CWORD: begin
            gb = gbuf_q | ({24'd0, in_byte_i} << {gcnt_q[1:0], 3'd0});
            gbuf_d = gb; gcnt_d = gcnt_q + 3'd1;
            if (gcnt_q == 3'd3) begin cw_d = gb; do_dec = 1'b1; end
          end
          lzfd_pkg::PH_TOKEN: begin
            gb = gbuf_q | ({24'd0, in_byte_i} << {gcnt_q[1:0], 3'd0});
            gbuf_d = gb; gc = gcnt_q + 3'd1; gcnt_d = gc;
            if (gc >= lzfd_pkg::token_len(gb[7:0])) begin
              v = gb;
              case (v[1:0])
                2'd0: begin off = {26'd0, v[7:2]}; len = 32'd3; end
                2'd1: begin off = {18'd0, v[15:2]}; len = 32'd3; end
                2'd2: begin off = {22'd0, v[15:6]}; len = {28'd0, v[5:2]} + 32'd3; end
                default: begin
                  if (v[6:0] == 7'd3) begin
                    len = {24'd0, v[14:7]} + 32'd3; off = {15'd0, v[31:15]};
                  end else begin
                    len = {27'd0, v[6:2]} + 32'd2; off = {15'd0, v[23:7]};
                  end
                end
              endcase
              cw_d = cw_q >> 1;
              if (off == '0 || off > pos_q || off > WIN) begin
                pdata_d = '0; pcnt_d = '0;
                emit = 1'b1; e_err = 1'b1; phase_d = lzfd_pkg::PH_IDLE;
              end else begin
                cp_d = 1'b1; off_d = off; cplen_d = len[8:0];
              end
            end
          end
          lzfd_pkg::PH_LITERAL: begin
            put_en = 1'b1;
          end
          lzfd_pkg::PH_TAIL: begin
            if (cw_q == lzfd_pkg::CW_EMPTY) begin
              phase_d = lzfd_pkg::PH_TAILSKIP; gcnt_d = 3'd1;
            end else begin
              cw_d = cw_q >> 1; put_en = 1'b1;
            end
          end
          lzfd_pkg::PH_TAILSKIP: begin
            gcnt_d = gcnt_q + 3'd1;
            if (gcnt_q == 3'd3) begin
              gcnt_d = '0; cw_d = lzfd_pkg::CW_TAIL; phase_d = lzfd_pkg::PH_TAIL;
            end
          end
          default: ;
        endcase
      end
    end

    // ---- produce one byte ----
    if (put_en) begin
      pdata_d = pdata_d | ({56'd0, pb} << {pcnt_d[2:0], 3'd0});
      pcnt_d = pcnt_d + 4'd1;
      pos_d = pos_q + 32'd1;
      done = (pos_d == fsize_q);
      if (pcnt_d == 4'd8 || done) begin
        emit = 1'b1; e_last = done;
      end
      if (done) begin
        phase_d = lzfd_pkg::PH_IDLE; stop = 1'b1;
      end else if (phase_q == lzfd_pkg::PH_LITERAL && !cp_q) begin
        if (lit_q > 3'd1) lit_d = lit_q - 3'd1;
        else begin lit_d = '0; do_dec = 1'b1; end
      end
    end

    // match end or overshoot
    if (cp_q) begin
      if (stop) begin
        cp_d = 1'b0; rd_d = 1'b0; cplen_d = '0;
      end else if (put_en && cplen_q == 9'd0 && !rd_d) begin
        cp_d = 1'b0; do_dec = 1'b1;
      end
    end

    // ---- top of decode loop ----
    if (do_dec) begin
      cwx = cw_d;
      gbuf_d = '0; gcnt_d = '0;
      if (cwx == lzfd_pkg::CW_EMPTY) phase_d = lzfd_pkg::PH_CWORD;
      else if (cwx[0]) phase_d = lzfd_pkg::PH_TOKEN;
      else if ({1'b0, pos_d} + 33'd11 >= {1'b0, fsize_d}) phase_d = lzfd_pkg::PH_TAIL;
      else begin
        nib = cwx[3:0];
        n = (nib == 4'd0) ? 3'd4 : nib[1] ? 3'd1 : nib[2] ? 3'd2 : 3'd3;
        lit_d = n; cw_d = cwx >> n; phase_d = lzfd_pkg::PH_LITERAL;
      end
    end

    if (emit) begin
      ovalid_d = 1'b1;
      ores_d.data  = e_err ? 64'd0 : pdata_d;
      ores_d.count = e_err ? 4'd0 : pcnt_d;
      ores_d.last  = e_last;
      ores_d.error = e_err;
      pdata_d = '0; pcnt_d = '0;
    end

    // history write
    we = put_en;
    waddr = AW'(pos_q);
    wdata = pb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lzfd_pkg::PH_IDLE; hidx_q <= '0; fsize_q <= '0; pos_q <= '0;
      cw_q <= lzfd_pkg::CW_EMPTY; gbuf_q <= '0; gcnt_q <= '0; lit_q <= '0;
      pdata_q <= '0; pcnt_q <= '0; cp_q <= 1'b0; rd_q <= 1'b0;
      cplen_q <= '0; off_q <= '0; ovalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hidx_q <= hidx_d; fsize_q <= fsize_d; pos_q <= pos_d;
      cw_q <= cw_d; gbuf_q <= gbuf_d; gcnt_q <= gcnt_d; lit_q <= lit_d;
      pdata_q <= pdata_d; pcnt_q <= pcnt_d; cp_q <= cp_d; rd_q <= rd_d;
      cplen_q <= cplen_d; off_q <= off_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ores_q <= ores_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = ores_q.data;
  assign out_count_o = ores_q.count;
  assign out_last_o  = ores_q.last;
  assign out_error_o = ores_q.error;

endmodule

[test/lzfd_checker.sv]
// Scoreboard for the LZ frame decompressor: watches both word channels, predicts
// the decoded result words and compares them. Depends on lzfd_pkg.
module lzfd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        frame_start_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] out_data_i,
  input  logic [3:0]  out_count_i,
  input  logic        out_last_i,
  input  logic        out_error_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned WIN = 131072;
  localparam int unsigned TAIL = 11;

  // decoder state mirror
  logic [7:0]  window_mem [0:WIN-1];
  logic [2:0]  ph;
  int unsigned hdr_idx, fsize, opos, cw, gbuf, gcnt, lit_left;
  logic [63:0] pack;
  int unsigned pack_n;
  lzfd_pkg::result_t words_q[$];

  assign pending_o = words_q.size();

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors_o++;
  endtask

  function void close_word(input logic last, input logic err);
    lzfd_pkg::result_t r;
    r.data = pack;
    r.count = pack_n[3:0];
    r.last = last;
    r.error = err;
    words_q.push_back(r);
    pack = '0;
    pack_n = 0;
  endfunction

  function void flag_error();
    pack = '0;
    pack_n = 0;
    close_word(1'b0, 1'b1);
    ph = lzfd_pkg::PH_IDLE;
  endfunction

  // write one decoded byte; returns 1 when the frame is complete
  function bit emit(input logic [7:0] b);
    bit done;
    window_mem[opos % WIN] = b;
    pack[8*pack_n +: 8] = b;
    pack_n++;
    opos++;
    done = (opos == fsize);
    if (done) ph = lzfd_pkg::PH_IDLE;
    if (pack_n == 8 || done) close_word(done, 1'b0);
    return done;
  endfunction

  // choose what the next bytes mean from the control word
  function void choose_next();
    int unsigned n;
    gbuf = 0;
    gcnt = 0;
    if (cw == 1) begin
      ph = lzfd_pkg::PH_CWORD;
    end else if (cw[0]) begin
      ph = lzfd_pkg::PH_TOKEN;
    end else if (longint'(opos) + TAIL >= longint'(fsize)) begin
      ph = lzfd_pkg::PH_TAIL;
    end else begin
      n = (cw[3:0] == 0) ? 4 : cw[1] ? 1 : cw[2] ? 2 : 3;
      lit_left = n;
      cw = cw >> n;
      ph = lzfd_pkg::PH_LITERAL;
    end
  endfunction

  function int unsigned token_bytes(input logic [7:0] b0);
    case (b0[1:0])
      2'd0:       return 1;
      2'd1, 2'd2: return 2;
      default:    return (b0[6:0] == 7'd3) ? 4 : 3;
    endcase
  endfunction

  function void copy_match();
    int unsigned off, len, i;
    logic [31:0] v;
    v = gbuf;
    case (v[1:0])
      2'd0: begin off = v[7:2]; len = 3; end
      2'd1: begin off = v[15:2]; len = 3; end
      2'd2: begin off = v[15:6]; len = v[5:2] + 3; end
      default: begin
        if (v[6:0] == 7'd3) begin
          len = v[14:7] + 3;
          off = v[31:15];
        end else begin
          len = v[6:2] + 2;
          off = v[23:7];
        end
      end
    endcase
    cw = cw >> 1;
    if (off == 0 || off > opos || off > WIN) begin
      flag_error();
      return;
    end
    for (i = 0; i < len; i++) begin
      if (emit(window_mem[(opos - off) % WIN])) return;
    end
    choose_next();
  endfunction

  function void open_body();
    hdr_idx = 0;
    opos = 0;
    lit_left = 0;
    if (fsize == 0) begin
      close_word(1'b1, 1'b0);
      ph = lzfd_pkg::PH_IDLE;
      return;
    end
    cw = 1;
    choose_next();
  endfunction

  function void predict(input logic [7:0] b, input logic s);
    pack = '0;
    pack_n = 0;
    if (s) begin
      opos = 0; fsize = 0; cw = 1; gbuf = 0; gcnt = 0; lit_left = 0;
      if (b == lzfd_pkg::FLAG_LONG) begin
        ph = lzfd_pkg::PH_HEADER; hdr_idx = 1;
      end else if (b == lzfd_pkg::FLAG_SHORT) begin
        ph = lzfd_pkg::PH_HEADER; hdr_idx = 10;
      end else begin
        hdr_idx = 0;
        flag_error();
      end
      return;
    end
    case (ph)
      lzfd_pkg::PH_HEADER: begin
        if (hdr_idx <= 8) begin
          if (hdr_idx >= 5) fsize = (fsize >> 8) | (int'(b) << 24);
          hdr_idx++;
          if (hdr_idx == 9) open_body();
        end else if (hdr_idx == 10) begin
          hdr_idx = 11;
        end else begin
          fsize = b;
          open_body();
        end
      end
      lzfd_pkg::PH_CWORD: begin
        gbuf |= int'(b) << (8 * (gcnt % 4));
        gcnt++;
        if (gcnt >= 4) begin
          cw = gbuf;
          choose_next();
        end
      end
      lzfd_pkg::PH_TOKEN: begin
        gbuf |= int'(b) << (8 * (gcnt % 4));
        gcnt++;
        if (gcnt >= token_bytes(gbuf[7:0])) copy_match();
      end
      lzfd_pkg::PH_LITERAL: begin
        if (!emit(b)) begin
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) choose_next();
        end
      end
      lzfd_pkg::PH_TAIL: begin
        if (cw == 1) begin
          ph = lzfd_pkg::PH_TAILSKIP;
          gcnt = 1;
        end else begin
          cw = cw >> 1;
          void'(emit(b));
        end
      end
      lzfd_pkg::PH_TAILSKIP: begin
        gcnt++;
        if (gcnt >= 4) begin
          gcnt = 0;
          cw = lzfd_pkg::CW_TAIL;
          ph = lzfd_pkg::PH_TAIL;
        end
      end
      default: ;
    endcase
  endfunction

  // compare accepted result words, then fold in accepted input words
  always @(posedge clk_i or negedge rst_ni) begin
    lzfd_pkg::result_t exp_w;
    if (!rst_ni) begin
      ph = lzfd_pkg::PH_IDLE;
      hdr_idx = 0; fsize = 0; opos = 0; cw = 1;
      gbuf = 0; gcnt = 0; lit_left = 0;
      errors_o = 0; checked_o = 0;
      words_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (words_q.size() == 0) begin
          report($sformatf("unexpected word data=%h cnt=%0d", out_data_i, out_count_i));
        end else begin
          exp_w = words_q.pop_front();
          if (out_data_i !== exp_w.data)
            report($sformatf("data %h, want %h", out_data_i, exp_w.data));
          if (out_count_i !== exp_w.count)
            report($sformatf("count %0d, want %0d", out_count_i, exp_w.count));
          if (out_last_i !== exp_w.last)
            report($sformatf("last %b, want %b", out_last_i, exp_w.last));
          if (out_error_i !== exp_w.error)
            report($sformatf("error %b, want %b", out_error_i, exp_w.error));
        end
      end
      if (in_valid_i && !in_stall_i) predict(in_byte_i, frame_start_i);
    end
  end

endmodule

[test/tb_lz_frame_decompressor_unit.sv]
// Testbench top for lz_frame_decompressor_unit: builds compressed frames and noise,
// drives them with random gaps and back-pressure. Depends on lzfd_pkg, lzfd_checker.
module tb_lz_frame_decompressor_unit;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_data_o;
  logic [3:0]  out_count_o;
  logic        out_last_o;
  logic        out_error_o;

  int errors, pending, checked;
  int words_sent, frames;
  bit quiet;
  int cut, sent;
  bit cut_hit;
  int stall_left;

  always #5 clk_i = ~clk_i;

  lz_frame_decompressor_unit dut (.*);

  lzfd_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_byte_i, .frame_start_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .out_data_i(out_data_o), .out_count_i(out_count_o),
    .out_last_i(out_last_o), .out_error_i(out_error_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // send one word, with an optional idle burst ahead of it
  task automatic put_word(input logic [7:0] b, input logic s, input bit counted);
    int k;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      k = $urandom_range(1, 8);
      repeat (k) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    frame_start_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (counted) words_sent++;
  endtask

  // body word; dropped once the frame has been cut short
  task automatic body_word(input logic [7:0] b);
    if (!cut_hit) begin
      put_word(b, 1'b0, 1'b1);
      sent++;
      if (cut >= 0 && sent >= cut) cut_hit = 1'b1;
    end
  endtask

  // encode one frame of the given size; cut_at aborts after that many body words,
  // bad ends it with an out-of-range match offset
  task automatic send_frame(input logic [31:0] size, input bit long_hdr,
                            input int cut_at, input bit bad);
    longint pos;
    logic [31:0] cw, v;
    int n, t, len, nb, maxoff, off, i;
    cut = cut_at;
    sent = 0;
    cut_hit = 1'b0;
    frames++;
    put_word(long_hdr ? lzfd_pkg::FLAG_LONG : lzfd_pkg::FLAG_SHORT, 1'b1, 1'b1);
    if (long_hdr) begin
      repeat (4) body_word(8'($urandom()));
      for (i = 0; i < 4; i++) body_word(size[8*i +: 8]);
    end else begin
      body_word(8'($urandom()));
      body_word(size[7:0]);
      size = {24'd0, size[7:0]};
    end
    pos = 0;
    cw = lzfd_pkg::CW_EMPTY;
    while (pos < size && !cut_hit) begin
      if (cw == lzfd_pkg::CW_EMPTY) begin
        cw = $urandom();
        cw[31] = 1'b1;
        if (pos == 0) cw[0] = 1'b0;
        if ($urandom_range(0, 9) == 0) cw = '0;
        for (i = 0; i < 4; i++) body_word(cw[8*i +: 8]);
      end else if (cw[0]) begin
        t = bad ? 4 : $urandom_range(0, 4);
        case (t)
          0: maxoff = 63;
          1: maxoff = 16383;
          2: maxoff = 1023;
          default: maxoff = 131071;
        endcase
        if (bad) off = $urandom_range(0, 1) ? 0 : int'(pos) + 1;
        else off = $urandom_range(1, (pos < maxoff) ? int'(pos) : maxoff);
        case (t)
          0: begin len = 3; nb = 1; v = off << 2; end
          1: begin len = 3; nb = 2; v = (off << 2) | 1; end
          2: begin
            len = $urandom_range(3, 18); nb = 2;
            v = (off << 6) | ((len - 3) << 2) | 2;
          end
          3: begin
            len = $urandom_range(3, 33); nb = 3;
            v = (off << 7) | ((len - 2) << 2) | 3;
          end
          default: begin
            len = $urandom_range(3, ($urandom_range(0, 7) == 0) ? 258 : 24); nb = 4;
            v = (off << 15) | ((len - 3) << 7) | 3;
          end
        endcase
        for (i = 0; i < nb; i++) body_word(v[8*i +: 8]);
        if (bad) return;
        pos += len;
        cw = cw >> 1;
      end else if (pos + 11 >= size) begin
        // tail literals, skipping a control word when one runs out
        while (pos < size && !cut_hit) begin
          if (cw == lzfd_pkg::CW_EMPTY) begin
            repeat (4) body_word(8'($urandom()));
            cw = lzfd_pkg::CW_TAIL;
          end
          body_word(8'($urandom()));
          cw = cw >> 1;
          pos++;
        end
      end else begin
        n = (cw[3:0] == 0) ? 4 : cw[1] ? 1 : cw[2] ? 2 : 3;
        repeat (n) body_word(8'($urandom()));
        pos += n;
        cw = cw >> n;
      end
    end
  endtask

  // hold the input idle until every predicted word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: noise, bad flag, zero and small sizes, huge size, restart, bad offset
    put_word(8'hFF, 1'b0, 1'b0);
    put_word(8'h00, 1'b1, 1'b1);
    send_frame(32'd0, 1'b0, -1, 1'b0);
    send_frame(32'd0, 1'b1, -1, 1'b0);
    send_frame(32'd5, 1'b0, -1, 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b1, 12, 1'b0);
    send_frame(32'd40, 1'b0, -1, 1'b1);
    send_frame(32'd255, 1'b0, -1, 1'b0);

    // random frames, noise and broken streams
    while (words_sent < 460) begin
      if (words_sent > 400) quiet = 1'b1;
      if (words_sent > 230 && words_sent < 260) drain();
      r = $urandom_range(0, 15);
      // no long frames near the end of the run
      if (words_sent > 360 && r == 4) r = 5;
      case (r)
        0: put_word(8'($urandom()), 1'b0, 1'b0);
        1: put_word($urandom_range(0, 1) ? 8'h6E : 8'hEF, 1'b1, 1'b1);
        2: send_frame($urandom_range(12, 80), 1'($urandom_range(0, 1)),
                      $urandom_range(1, 30), 1'b0);
        3: send_frame($urandom_range(12, 80), 1'($urandom_range(0, 1)), -1, 1'b1);
        4: send_frame($urandom_range(100, 400), 1'b1, -1, 1'b0);
        default: send_frame($urandom_range(1, 60), 1'($urandom_range(0, 1)), -1, 1'b0);
      endcase
    end
    in_valid_i <= 1'b0;
    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d words over %0d frame headers; %0d result words checked.",
             words_sent, frames, checked);
    if (errors == 0) $display("tb_lz_frame_decompressor_unit passed");
    else $display("tb_lz_frame_decompressor_unit failed");
    $finish;
  end

  // run limit
  initial begin
    #30000000;
    $display("tb_lz_frame_decompressor_unit failed");
    $finish;
  end

endmodule
